FILE: rtl/efsd_pkg.sv
// shared constants and types for the earliest-free server dispatch block
package efsd_pkg;

    localparam int NUM_ROOMS = 16;
    localparam int TIME_BITS = 48;

    localparam int ROOM_BITS = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
    localparam int ACT_BITS  = $clog2(NUM_ROOMS + 1);
    localparam int CNT_BITS  = 32;
    localparam int IN_TIME_BITS = 32;
    localparam int CFG_BITS  = 5;
    localparam int OUT_ROOM_BITS = 4;
    localparam int OUT_TIME_BITS = 48;

    localparam logic [CFG_BITS-1:0] ROOM_COUNT_RESET = CFG_BITS'(16);

    // search record passed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [ROOM_BITS-1:0] idx;
        logic [TIME_BITS-1:0] ftime;
        logic [CNT_BITS-1:0]  count;
    } probe_t;

    // update broadcast to the cells at the end of a job
    typedef struct packed {
        logic                 en;
        logic [ROOM_BITS-1:0] idx;
        logic [TIME_BITS-1:0] ftime;
        logic [CNT_BITS-1:0]  count;
    } wr_t;

endpackage

FILE: rtl/efsd_if.sv
// job and result channel interfaces
interface efsd_job_if;
    import efsd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    first_of_batch;
    logic [IN_TIME_BITS-1:0] start_time;
    logic [IN_TIME_BITS-1:0] end_time;

    modport source (output valid, output first_of_batch, output start_time,
                    output end_time, input ready);
    modport sink (input valid, input first_of_batch, input start_time,
                  input end_time, output ready);
endinterface

interface efsd_res_if;
    import efsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OUT_ROOM_BITS-1:0] assigned_room;
    logic                     was_delayed;
    logic [OUT_TIME_BITS-1:0] finish_time;
    logic [OUT_ROOM_BITS-1:0] busiest_room;
    logic [CNT_BITS-1:0]      busiest_count;

    modport source (output valid, output assigned_room, output was_delayed,
                    output finish_time, output busiest_room, output busiest_count,
                    input ready);
    modport sink (input valid, input assigned_room, input was_delayed,
                  input finish_time, input busiest_room, input busiest_count,
                  output ready);
endinterface

FILE: rtl/efsd_cell.sv
// one server cell: holds free time and use count, refines the passing search record
module efsd_cell
    import efsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ROOM_BITS-1:0]    cell_idx,
    input  logic [ACT_BITS-1:0]     active,
    input  logic [IN_TIME_BITS-1:0] start_time,
    input  logic                    clear,
    input  wr_t                     wr,
    input  probe_t                  probe_in,
    output probe_t                  probe_out
);

    logic [TIME_BITS-1:0] free_at_reg;
    logic [CNT_BITS-1:0]  use_count_reg;
    probe_t               probe_reg;
    probe_t               probe_next;
    logic                 in_use;
    logic                 is_free;
    logic                 is_earlier;

    assign in_use     = ACT_BITS'(cell_idx) < active;
    assign is_free    = free_at_reg <= TIME_BITS'(start_time);
    // the first cell always seeds the earliest candidate
    assign is_earlier = (cell_idx == '0) || (free_at_reg < probe_in.ftime);

    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.found && in_use)
        begin
            if (is_free)
            begin
                probe_next.found = 1'b1;
                probe_next.idx   = cell_idx;
                probe_next.ftime = free_at_reg;
                probe_next.count = use_count_reg;
            end
            else if (is_earlier)
            begin
                probe_next.idx   = cell_idx;
                probe_next.ftime = free_at_reg;
                probe_next.count = use_count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_at_reg   <= '0;
            use_count_reg <= '0;
            probe_reg     <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (clear)
            begin
                free_at_reg   <= '0;
                use_count_reg <= '0;
            end
            else if (wr.en && wr.idx == cell_idx)
            begin
                free_at_reg   <= wr.ftime;
                use_count_reg <= wr.count;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

FILE: rtl/earliest_free_server_dispatch.sv
// top level: job intake, cell chain, write-back and busiest-server tracking
//
//  channel  | dir | handshake     | payload
//  job      | in  | valid/ready   | first_of_batch, start_time, end_time
//  res      | out | valid/ready   | assigned_room, was_delayed, finish_time,
//           |     |               | busiest_room, busiest_count
//  cfg      | in  | cfg_wr_en     | cfg_wr_data (room_count)
//
// a job passes through accept, launch, a registered step in each cell of the
// chain, then write-back into the chosen cell and the result register.
// one job is in flight at a time; the next job is taken while a result waits.
// write-back stalls while the result register is still full.
// reset clears all cells at once, room_count resets to 16.
module earliest_free_server_dispatch
    import efsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    efsd_job_if.sink            job,
    efsd_res_if.source          res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CFG_BITS-1:0]     room_count_reg;
    logic [ACT_BITS-1:0]     active;
    logic [IN_TIME_BITS-1:0] start_reg;
    logic [IN_TIME_BITS-1:0] end_reg;
    logic [IN_TIME_BITS-1:0] dur_reg;
    logic                    launch_reg;
    logic                    clear;
    probe_t                  found_reg;
    probe_t                  chain [NUM_ROOMS+1];
    wr_t                     wr;
    logic [ROOM_BITS-1:0]    top_room_reg;
    logic [CNT_BITS-1:0]     top_count_reg;
    logic                    out_valid_reg;
    logic [OUT_ROOM_BITS-1:0] out_room_reg;
    logic                    out_delayed_reg;
    logic [OUT_TIME_BITS-1:0] out_time_reg;
    logic [OUT_ROOM_BITS-1:0] out_top_room_reg;
    logic [CNT_BITS-1:0]     out_top_count_reg;
    logic                    job_acc;
    logic                    finish;
    logic [TIME_BITS:0]      delayed_sum;
    logic [TIME_BITS-1:0]    new_time;
    logic [CNT_BITS-1:0]     new_count;
    logic                    top_take;

    assign job.ready = (state_reg == ST_IDLE);
    assign job_acc   = job.valid && job.ready;
    assign clear     = job_acc && job.first_of_batch;
    assign finish    = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        if (32'(room_count_reg) > NUM_ROOMS)
            active = ACT_BITS'(NUM_ROOMS);
        else if (room_count_reg == '0)
            active = ACT_BITS'(1);
        else
            active = ACT_BITS'(room_count_reg);
    end

    assign chain[0] = '{valid: launch_reg, found: 1'b0, idx: '0, ftime: '0, count: '0};

    for (genvar i = 0; i < NUM_ROOMS; i++)
    begin : g_cell
        efsd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (ROOM_BITS'(i)),
            .active     (active),
            .start_time (start_reg),
            .clear      (clear),
            .wr         (wr),
            .probe_in   (chain[i]),
            .probe_out  (chain[i+1])
        );
    end

    // postponed finish saturates at the top of the time range
    assign delayed_sum = {1'b0, found_reg.ftime} + (TIME_BITS+1)'(dur_reg);
    always_comb
    begin
        if (found_reg.found)
            new_time = TIME_BITS'(end_reg);
        else if (delayed_sum[TIME_BITS])
            new_time = '1;
        else
            new_time = delayed_sum[TIME_BITS-1:0];
    end

    assign new_count = (found_reg.count == '1) ? found_reg.count : found_reg.count + 1'b1;
    assign top_take  = (new_count > top_count_reg) ||
                       (new_count == top_count_reg && found_reg.idx < top_room_reg);

    assign wr = '{en: finish, idx: found_reg.idx, ftime: new_time, count: new_count};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_acc) state_next = ST_SCAN;
            ST_SCAN: if (chain[NUM_ROOMS].valid) state_next = ST_DONE;
            ST_DONE: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            room_count_reg <= ROOM_COUNT_RESET;
            launch_reg     <= 1'b0;
            top_room_reg   <= '0;
            top_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= job_acc;
            if (cfg_wr_en)
                room_count_reg <= cfg_wr_data;
            if (clear)
            begin
                top_room_reg  <= '0;
                top_count_reg <= '0;
            end
            else if (finish && top_take)
            begin
                top_room_reg  <= found_reg.idx;
                top_count_reg <= new_count;
            end
            if (finish)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_acc)
        begin
            start_reg <= job.start_time;
            end_reg   <= job.end_time;
            dur_reg   <= (job.end_time > job.start_time) ?
                         job.end_time - job.start_time : '0;
        end
        if (state_reg == ST_SCAN && chain[NUM_ROOMS].valid)
            found_reg <= chain[NUM_ROOMS];
        if (finish)
        begin
            out_room_reg      <= OUT_ROOM_BITS'(found_reg.idx);
            out_delayed_reg   <= !found_reg.found;
            out_time_reg      <= OUT_TIME_BITS'(new_time);
            out_top_room_reg  <= top_take ? OUT_ROOM_BITS'(found_reg.idx)
                                          : OUT_ROOM_BITS'(top_room_reg);
            out_top_count_reg <= top_take ? new_count : top_count_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.assigned_room = out_room_reg;
    assign res.was_delayed   = out_delayed_reg;
    assign res.finish_time   = out_time_reg;
    assign res.busiest_room  = out_top_room_reg;
    assign res.busiest_count = out_top_count_reg;

endmodule
